### rtl/assert_macros.svh
// Assertion macros used by the checker module of this block.
// Every assertion is clocked on the rising edge and is off while reset is held.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define ASSERT_SAME(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(name, clk, rst_n, ante, cons, msg) \
    name: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/rdq_pkg.sv
// ----------------------------------------------------------------------------
// rdq_pkg
// Shared constants and operation codes for the reversible deque queue.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package rdq_pkg;

    localparam int DEPTH_DEFAULT = 16;

    localparam int OP_W    = 2;
    localparam int VALUE_W = 32;
    localparam int COUNT_W = 5;

    typedef logic [OP_W-1:0] op_t;

    localparam op_t OP_PUSH_HEAD = 2'd0;
    localparam op_t OP_PUSH_TAIL = 2'd1;
    localparam op_t OP_POP_HEAD  = 2'd2;
    localparam op_t OP_REVERSE   = 2'd3;

endpackage

### rtl/reversible_deque_queue_core.sv
// ----------------------------------------------------------------------------
// reversible_deque_queue_core
// Bounded double-ended queue of signed 32-bit values held in a ring buffer
// memory, with a direction flag that reverses the order in one operation.
// ----------------------------------------------------------------------------
//  Channel  Handshake            Payload
//  in       in_valid / in_stall  operation, value
//  out      out_valid / out_stall ok, removed_value, item_count
//
//  Every accepted beat gives exactly one result beat on the next cycle.
//  One operation per cycle is sustained while no result waits under out_stall:
//  each touches one memory entry, and the store has a registered read port.
//  Reset empties the queue and clears the direction flag; the store itself is
//  not cleared, since only written entries are ever read.
//  in_stall is high only while a finished result waits under out_stall.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module reversible_deque_queue_core #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
    input  logic                               clk,
    input  logic                               rst_n,
    input  logic                               in_valid,
    output logic                               in_stall,
    input  rdq_pkg::op_t                       operation,
    input  logic signed [rdq_pkg::VALUE_W-1:0] value,
    output logic                               out_valid,
    input  logic                               out_stall,
    output logic                               ok,
    output logic signed [rdq_pkg::VALUE_W-1:0] removed_value,
    output logic        [rdq_pkg::COUNT_W-1:0] item_count
);

    localparam int IDX_W = $clog2(DEPTH);
    localparam int CNT_W = $clog2(DEPTH + 1);
    localparam logic [IDX_W:0]   DEPTH_WIDE = (IDX_W + 1)'(DEPTH);
    localparam logic [CNT_W-1:0] DEPTH_CNT  = CNT_W'(DEPTH);
    localparam logic [IDX_W-1:0] LAST_SLOT  = IDX_W'(DEPTH - 1);

    // Ring buffer store.
    logic signed [rdq_pkg::VALUE_W-1:0] mem [DEPTH];
    logic signed [rdq_pkg::VALUE_W-1:0] rd_data_reg;

    logic [IDX_W-1:0] front_reg, front_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic             rev_reg, rev_next;

    logic             out_valid_reg;
    logic             ok_reg, ok_next;
    logic             popped_reg, popped_next;
    logic [CNT_W-1:0] out_count_reg;

    logic             accept;
    logic             full, empty;
    logic             to_front;
    logic             wr_en, rd_en;
    logic [IDX_W-1:0] offset;
    logic [IDX_W:0]   slot_sum;
    logic [IDX_W-1:0] slot;
    logic [IDX_W-1:0] before_front;
    logic [IDX_W-1:0] addr;

    assign accept   = in_valid && !in_stall;
    assign in_stall = out_valid_reg && out_stall;
    assign full     = (count_reg == DEPTH_CNT);
    assign empty    = (count_reg == '0);

    // An insert lands before the front when it targets the head in normal
    // order or the tail in reversed order.
    assign to_front = (operation == rdq_pkg::OP_PUSH_HEAD) ^ rev_reg;

    assign before_front = (front_reg == '0) ? LAST_SLOT : front_reg - 1'b1;

    always_comb
    begin
        offset = count_reg[IDX_W-1:0];
        if (operation == rdq_pkg::OP_POP_HEAD)
        begin
            offset = rev_reg ? IDX_W'(count_reg - 1'b1) : IDX_W'(1);
        end
    end

    // Ring slot at the chosen offset from the front; both terms are below
    // DEPTH, so one conditional subtract wraps it.
    assign slot_sum = {1'b0, front_reg} + {1'b0, offset};
    assign slot     = (slot_sum >= DEPTH_WIDE) ? IDX_W'(slot_sum - DEPTH_WIDE)
                                               : slot_sum[IDX_W-1:0];

    always_comb
    begin
        front_next  = front_reg;
        count_next  = count_reg;
        rev_next    = rev_reg;
        ok_next     = 1'b0;
        popped_next = 1'b0;
        wr_en       = 1'b0;
        rd_en       = 1'b0;
        addr        = slot;
        unique case (operation)
            rdq_pkg::OP_PUSH_HEAD, rdq_pkg::OP_PUSH_TAIL:
            begin
                if (!full)
                begin
                    ok_next    = 1'b1;
                    wr_en      = 1'b1;
                    count_next = count_reg + 1'b1;
                    if (to_front)
                    begin
                        addr       = before_front;
                        front_next = before_front;
                    end
                end
            end
            rdq_pkg::OP_POP_HEAD:
            begin
                if (!empty)
                begin
                    ok_next     = 1'b1;
                    popped_next = 1'b1;
                    rd_en       = 1'b1;
                    count_next  = count_reg - 1'b1;
                    if (rev_reg)
                    begin
                        addr = slot;
                    end
                    else
                    begin
                        addr       = front_reg;
                        front_next = slot;
                    end
                    // Taking the last item resets the ring to slot zero.
                    if (count_reg == CNT_W'(1))
                    begin
                        front_next = '0;
                    end
                end
            end
            rdq_pkg::OP_REVERSE:
            begin
                ok_next  = 1'b1;
                rev_next = !rev_reg;
            end
            default:
            begin
                ok_next = 1'b0;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (accept && wr_en)
        begin
            mem[addr] <= value;
        end
        if (accept && rd_en)
        begin
            rd_data_reg <= mem[addr];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            front_reg     <= '0;
            count_reg     <= '0;
            rev_reg       <= 1'b0;
            out_valid_reg <= 1'b0;
            ok_reg        <= 1'b0;
            popped_reg    <= 1'b0;
            out_count_reg <= '0;
        end
        else
        begin
            if (accept)
            begin
                front_reg     <= front_next;
                count_reg     <= count_next;
                rev_reg       <= rev_next;
                out_valid_reg <= 1'b1;
                ok_reg        <= ok_next;
                popped_reg    <= popped_next;
                out_count_reg <= count_next;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    assign out_valid     = out_valid_reg;
    assign ok            = ok_reg;
    assign removed_value = popped_reg ? rd_data_reg : '0;
    assign item_count    = rdq_pkg::COUNT_W'(out_count_reg);

endmodule

### rtl/rdq_checker.sv
// ----------------------------------------------------------------------------
// rdq_checker
// Port-level checks for the reversible deque queue, bound to the top level.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "assert_macros.svh"

module rdq_checker #(
    parameter int DEPTH = rdq_pkg::DEPTH_DEFAULT
) (
    input logic                               clk,
    input logic                               rst_n,
    input logic                               in_valid,
    input logic                               in_stall,
    input rdq_pkg::op_t                       operation,
    input logic                               out_valid,
    input logic                               out_stall,
    input logic                               ok,
    input logic signed [rdq_pkg::VALUE_W-1:0] removed_value,
    input logic        [rdq_pkg::COUNT_W-1:0] item_count
);

    logic in_beat;
    logic rev_beat;

    assign in_beat  = in_valid && !in_stall;
    assign rev_beat = in_beat && (operation == rdq_pkg::OP_REVERSE);

    // Each accepted beat produces its result on the following cycle.
    `ASSERT_NEXT(a_result_follows, clk, rst_n, in_beat, out_valid,
                 "accepted beat did not produce a result")

    // A refused result carries a zero value.
    `ASSERT_SAME(a_refused_zero, clk, rst_n, out_valid && !ok, removed_value == '0,
                 "refused result carries a nonzero value")

    // A reverse never fails.
    `ASSERT_NEXT(a_reverse_ok, clk, rst_n, rev_beat, ok,
                 "reverse reported failure")

    // The count never exceeds the depth while it fits the count field.
    `ASSERT_SAME(a_count_bound, clk, rst_n, out_valid,
                 (DEPTH > 31) || (item_count <= rdq_pkg::COUNT_W'(DEPTH)),
                 "item count exceeds depth")

    // A waiting result is held until taken.
    `ASSERT_NEXT(a_hold_result, clk, rst_n, out_valid && out_stall,
                 out_valid && $stable(removed_value) && $stable(item_count),
                 "stalled result changed")

endmodule

bind reversible_deque_queue_core rdq_checker #(.DEPTH(DEPTH)) u_rdq_checker (.*);

### sim/tb_reversible_deque_queue_core.sv
// ----------------------------------------------------------------------------
// tb_reversible_deque_queue_core
// Self-checking bench for the reversible deque queue. A short directed table
// walks empty, full and reversed corners, then biased random fill and drain
// runs follow. Each result beat is compared with a typed row's result or a
// deque model kept in step with accepted beats, under random idling and stalls.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb_reversible_deque_queue_core;

    localparam int QDEPTH      = rdq_pkg::DEPTH_DEFAULT;
    localparam int RAND_ITEMS  = 1200;
    localparam int HOLD_LEN    = 80;
    localparam int CYCLE_LIMIT = 200000;
    localparam int MAX_SHOWN   = 10;

    typedef struct packed {
        logic                               ok;
        logic signed [rdq_pkg::VALUE_W-1:0] removed;
        logic        [rdq_pkg::COUNT_W-1:0] count;
    } dq_result_t;

    typedef struct {
        rdq_pkg::op_t op;
        logic [31:0]  val;
        int           reps;
        bit           typed;
        dq_result_t   res;
    } dq_row_t;

    logic                               clk = 1'b0;
    logic                               rst_n = 1'b0;
    logic                               in_valid = 1'b0;
    logic                               in_stall;
    rdq_pkg::op_t                       operation = rdq_pkg::OP_PUSH_HEAD;
    logic signed [rdq_pkg::VALUE_W-1:0] value = '0;
    logic                               out_valid;
    logic                               out_stall = 1'b0;
    logic                               ok;
    logic signed [rdq_pkg::VALUE_W-1:0] removed_value;
    logic        [rdq_pkg::COUNT_W-1:0] item_count;

    // Deque model state.
    logic [31:0] model_mem [QDEPTH];
    int          model_front;
    int          model_count;
    bit          model_rev;

    dq_result_t  pending_results[$];
    dq_row_t     dir_rows[$];
    dq_result_t  predicted;
    dq_result_t  wanted;
    dq_result_t  beat_typed_res;
    bit          beat_typed;
    int          error_count;
    int          cycle_count;
    bit          calm;
    bit          hold_start;
    int          hold_left;

    reversible_deque_queue_core #(
        .DEPTH(QDEPTH)
    ) dut (
        .clk          (clk),
        .rst_n        (rst_n),
        .in_valid     (in_valid),
        .in_stall     (in_stall),
        .operation    (operation),
        .value        (value),
        .out_valid    (out_valid),
        .out_stall    (out_stall),
        .ok           (ok),
        .removed_value(removed_value),
        .item_count   (item_count)
    );

    always
    begin
        #4 clk = 1'b1;
        #4 clk = 1'b0;
    end

    // Applies one operation to the deque model and returns its result.
    function automatic dq_result_t deque_apply(rdq_pkg::op_t op, logic [31:0] v);
        dq_result_t r;
        r = '0;
        case (op)
            rdq_pkg::OP_PUSH_HEAD, rdq_pkg::OP_PUSH_TAIL:
            begin
                if (model_count < QDEPTH)
                begin
                    // The logical head is the physical front unless reversed.
                    if ((op == rdq_pkg::OP_PUSH_HEAD) != model_rev)
                    begin
                        model_front = (model_front + QDEPTH - 1) % QDEPTH;
                        model_mem[model_front] = v;
                    end
                    else
                    begin
                        model_mem[(model_front + model_count) % QDEPTH] = v;
                    end
                    model_count++;
                    r.ok = 1'b1;
                end
            end
            rdq_pkg::OP_POP_HEAD:
            begin
                if (model_count != 0)
                begin
                    if (model_rev)
                    begin
                        r.removed = model_mem[(model_front + model_count - 1) % QDEPTH];
                    end
                    else
                    begin
                        r.removed = model_mem[model_front];
                        model_front = (model_front + 1) % QDEPTH;
                    end
                    model_count--;
                    if (model_count == 0)
                    begin
                        model_front = 0;
                    end
                    r.ok = 1'b1;
                end
            end
            default:
            begin
                model_rev = !model_rev;
                r.ok = 1'b1;
            end
        endcase
        r.count = model_count[rdq_pkg::COUNT_W-1:0];
        return r;
    endfunction

    // Predicts on every accepted input beat and checks every accepted result.
    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if (in_valid && !in_stall)
            begin
                predicted = deque_apply(operation, value);
                pending_results.push_back(beat_typed ? beat_typed_res : predicted);
            end
            if (out_valid && !out_stall)
            begin
                if (pending_results.size() == 0)
                begin
                    error_count++;
                    if (error_count <= MAX_SHOWN)
                    begin
                        $display("%0t: unexpected result ok=%0d rv=%0d cnt=%0d",
                                 $realtime, ok, removed_value, item_count);
                    end
                end
                else
                begin
                    wanted = pending_results.pop_front();
                    if (ok !== wanted.ok || removed_value !== wanted.removed ||
                        item_count !== wanted.count)
                    begin
                        error_count++;
                        if (error_count <= MAX_SHOWN)
                        begin
                            $display("%0t: exp ok=%0d rv=%0d cnt=%0d",
                                     $realtime, wanted.ok, wanted.removed, wanted.count);
                            $display("%0t: got ok=%0d rv=%0d cnt=%0d",
                                     $realtime, ok, removed_value, item_count);
                        end
                    end
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    // Receiver: random stalls, a calm stretch, and one long hold-off on request.
    initial
    begin
        forever
        begin
            @(negedge clk);
            if (hold_left > 0)
            begin
                out_stall <= 1'b1;
                hold_left--;
            end
            else if (hold_start)
            begin
                hold_start = 1'b0;
                hold_left = HOLD_LEN - 1;
                out_stall <= 1'b1;
            end
            else
            begin
                out_stall <= !calm && ($urandom_range(99) < 22);
            end
        end
    end

    task automatic add_row(rdq_pkg::op_t op, logic [31:0] val, int reps, bit typed,
                           logic rok, logic [31:0] rrem, int rcnt);
        dq_row_t row;
        row.op = op;
        row.val = val;
        row.reps = reps;
        row.typed = typed;
        row.res.ok = rok;
        row.res.removed = rrem;
        row.res.count = rcnt[rdq_pkg::COUNT_W-1:0];
        dir_rows.push_back(row);
    endtask

    task automatic idle_cycle();
        @(negedge clk);
        in_valid <= 1'b0;
    endtask

    // Offers one beat and holds it until the block takes it.
    task automatic send_beat(rdq_pkg::op_t op, logic [31:0] val, bit typed,
                             dq_result_t res);
        @(negedge clk);
        in_valid <= 1'b1;
        operation <= op;
        value <= val;
        beat_typed = typed;
        beat_typed_res = res;
        do
            @(posedge clk);
        while (in_stall);
    endtask

    initial
    begin
        int           i;
        int           k;
        int           mode;
        int           pick;
        int           fill_pct;
        rdq_pkg::op_t op;
        logic [31:0]  v;
        dq_row_t      row;

        error_count = 0;
        cycle_count = 0;
        calm = 1'b0;
        hold_start = 1'b0;
        hold_left = 0;
        beat_typed = 1'b0;
        beat_typed_res = '0;
        model_front = 0;
        model_count = 0;
        model_rev = 1'b0;

        repeat (12) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        add_row(rdq_pkg::OP_POP_HEAD,  32'h0,        1,  1, 0, 32'h0,        0);
        add_row(rdq_pkg::OP_REVERSE,   32'h0,        1,  1, 1, 32'h0,        0);
        add_row(rdq_pkg::OP_PUSH_HEAD, 32'h7fffffff, 1,  1, 1, 32'h0,        1);
        add_row(rdq_pkg::OP_REVERSE,   32'h0,        1,  1, 1, 32'h0,        1);
        add_row(rdq_pkg::OP_POP_HEAD,  32'hffffffff, 1,  1, 1, 32'h7fffffff, 0);
        add_row(rdq_pkg::OP_PUSH_TAIL, 32'h80000000, 1,  1, 1, 32'h0,        1);
        add_row(rdq_pkg::OP_PUSH_HEAD, 32'h0,        1,  0, 0, 32'h0,        0);
        add_row(rdq_pkg::OP_PUSH_TAIL, 32'hffffffff, 1,  0, 0, 32'h0,        0);
        add_row(rdq_pkg::OP_PUSH_HEAD, 32'h55555500, 13, 0, 0, 32'h0,        0);
        // The queue is now full, so both inserts are refused.
        add_row(rdq_pkg::OP_PUSH_TAIL, 32'haaaaaaaa, 1,  1, 0, 32'h0,        16);
        add_row(rdq_pkg::OP_PUSH_HEAD, 32'h12345678, 1,  1, 0, 32'h0,        16);
        add_row(rdq_pkg::OP_REVERSE,   32'h0,        1,  1, 1, 32'h0,        16);
        add_row(rdq_pkg::OP_PUSH_TAIL, 32'h00000001, 1,  1, 0, 32'h0,        16);
        add_row(rdq_pkg::OP_POP_HEAD,  32'h0,        16, 0, 0, 32'h0,        0);
        add_row(rdq_pkg::OP_POP_HEAD,  32'h0,        1,  1, 0, 32'h0,        0);
        add_row(rdq_pkg::OP_REVERSE,   32'h0,        1,  1, 1, 32'h0,        0);
        add_row(rdq_pkg::OP_PUSH_TAIL, 32'h00000001, 1,  0, 0, 32'h0,        0);
        add_row(rdq_pkg::OP_PUSH_HEAD, 32'h00000002, 1,  0, 0, 32'h0,        0);
        add_row(rdq_pkg::OP_POP_HEAD,  32'h0,        1,  0, 0, 32'h0,        0);
        add_row(rdq_pkg::OP_REVERSE,   32'h0,        1,  0, 0, 32'h0,        0);
        add_row(rdq_pkg::OP_POP_HEAD,  32'h0,        1,  0, 0, 32'h0,        0);

        foreach (dir_rows[r])
        begin
            row = dir_rows[r];
            for (k = 0; k < row.reps; k++)
            begin
                if ($urandom_range(99) < 22)
                begin
                    idle_cycle();
                end
                send_beat(row.op, row.val + k, row.typed, row.res);
            end
        end

        // Random part: runs of fill-heavy, drain-heavy and balanced traffic so
        // that the queue swings between empty and full many times.
        mode = 0;
        for (i = 0; i < RAND_ITEMS; i++)
        begin
            if (i % 50 == 0)
            begin
                mode = $urandom_range(2);
            end
            calm = (i >= 500 && i < 700);
            if (i == 300)
            begin
                hold_start = 1'b1;
            end
            if (i == 900)
            begin
                idle_cycle();
                while (pending_results.size() != 0)
                begin
                    idle_cycle();
                end
            end
            while (!calm && $urandom_range(99) < 22)
            begin
                idle_cycle();
            end

            if (mode == 0)
            begin
                fill_pct = 75;
            end
            else if (mode == 1)
            begin
                fill_pct = 32;
            end
            else
            begin
                fill_pct = 55;
            end

            pick = $urandom_range(99);
            if (pick < 10)
            begin
                op = rdq_pkg::OP_REVERSE;
            end
            else if (pick < fill_pct)
            begin
                op = pick[0] ? rdq_pkg::OP_PUSH_HEAD : rdq_pkg::OP_PUSH_TAIL;
            end
            else
            begin
                op = rdq_pkg::OP_POP_HEAD;
            end

            case ($urandom_range(15))
                0:       v = 32'h7fffffff;
                1:       v = 32'h80000000;
                2:       v = 32'hffffffff;
                3:       v = 32'h0;
                default: v = $urandom;
            endcase
            send_beat(op, v, 1'b0, '0);
        end

        idle_cycle();
        while (pending_results.size() != 0)
        begin
            idle_cycle();
        end
        repeat (8) idle_cycle();

        if (pending_results.size() != 0)
        begin
            error_count++;
        end
        if (error_count == 0)
        begin
            $display("DONE: 0 errors");
        end
        else
        begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
